FILE: rtl/core/prmu_pkg.sv
// Shared types, widths and the factorial table for the permutation unranker.
// No dependencies; every other file of the block imports this package.
package prmu_pkg;

  localparam int RANK_W = 29;
  localparam int ELEM_W = 4;
  localparam int CFG_W  = 4;
  localparam int DATA_W = 32;

  // Token that walks down the cell chain: the running value of one digit.
  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] value;
  } tok_t;

  // Digit held by one cell, with its occupied flag.
  typedef struct packed {
    logic              occ;
    logic [ELEM_W-1:0] digit;
  } slot_t;

  function automatic logic [RANK_W-1:0] fact(input logic [CFG_W-1:0] k);
    logic [RANK_W-1:0] f;
    case (k)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd479001600;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/core/permutation_unrank.sv
// Top level of the lexicographic permutation unranker: control, digit extraction,
// configuration port and output register. Depends on prmu_pkg and prmu_cell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  rank     | rank_valid / rank_stall| perm_rank[28:0]
//  element  | elem_valid / elem_stall| element_value[3:0], last_element, rank_error
//  config   | APB psel/penable/pready| paddr[2:0], pwdata/prdata[31:0]
//
// Per item: an accept step, then for each position i a factorial subtraction
// loop, a pass of the digit through the cell chain and a write step.
// A rank of n! or more goes from accept straight to the write step and gives
// a single error beat. rst is synchronous and clears control.
// A stalled element beat holds; work on the next position goes on behind it.
module permutation_unrank #(
  parameter int MAX_LEN = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [prmu_pkg::DATA_W-1:0]   pwdata,
  output logic [prmu_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          rank_valid,
  output logic                          rank_stall,
  input  logic [prmu_pkg::RANK_W-1:0]   perm_rank,
  output logic                          elem_valid,
  input  logic                          elem_stall,
  output logic [prmu_pkg::ELEM_W-1:0]   element_value,
  output logic                          last_element,
  output logic                          rank_error
);
  import prmu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXTRACT = 4'b0010,
    ST_TRAVEL  = 4'b0100,
    ST_WRITE   = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  perm_length;
  logic [CFG_W-1:0]  n_eff;
  logic [RANK_W-1:0] rem;
  logic [RANK_W-1:0] fval;
  logic [CFG_W-1:0]  pos;
  logic [ELEM_W-1:0] dig;
  logic [ELEM_W-1:0] res_value;
  logic              err;
  logic              ge;
  logic              accept;
  logic              out_free;
  logic              is_last;
  logic              clear;
  logic              shift;
  tok_t              tok_link  [MAX_LEN+1];
  slot_t             slot_link [MAX_LEN+1];
  logic [MAX_LEN:0]  tok_valid_vec;

  // Configuration: one register at index 0 (paddr[2] low); addresses with paddr[2] high are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(DATA_W-CFG_W){1'b0}}, perm_length} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= 4'd12;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      perm_length <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    n_eff = perm_length;
    if (perm_length == '0) begin
      n_eff = 4'd1;
    end
    if (perm_length > CFG_W'(MAX_LEN)) begin
      n_eff = CFG_W'(MAX_LEN);
    end
  end

  assign rank_stall = (state != ST_IDLE);
  assign accept     = rank_valid && !rank_stall;
  assign out_free   = !elem_valid || !elem_stall;
  assign fval       = fact(n_eff - 4'd1 - pos);
  assign ge         = (rem >= fval);
  assign is_last    = err || (pos == (n_eff - 4'd1));
  assign clear      = accept;
  assign shift      = (state == ST_TRAVEL) && tok_link[MAX_LEN].valid;

  // Launch the finished digit into the chain; insert it behind the token on return.
  assign tok_link[0].valid  = (state == ST_EXTRACT) && !ge;
  assign tok_link[0].value  = dig;
  assign slot_link[0].occ   = 1'b1;
  assign slot_link[0].digit = dig;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    prmu_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .clear  (clear),
      .shift  (shift),
      .slot_i (slot_link[k]),
      .slot_o (slot_link[k+1]),
      .tok_i  (tok_link[k]),
      .tok_o  (tok_link[k+1])
    );
  end

  for (genvar k = 0; k <= MAX_LEN; k++) begin : g_vec
    assign tok_valid_vec[k] = tok_link[k].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elem_valid <= 1'b0;
    end else begin
      // Drop the taken beat unless a new one is written in this cycle.
      if (elem_valid && !elem_stall && (state != ST_WRITE)) begin
        elem_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (perm_rank >= fact(n_eff)) ? ST_WRITE : ST_EXTRACT;
          end
        end
        ST_EXTRACT: begin
          if (!ge) begin
            state <= ST_TRAVEL;
          end
        end
        ST_TRAVEL: begin
          if (tok_link[MAX_LEN].valid) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            elem_valid <= 1'b1;
            state      <= is_last ? ST_IDLE : ST_EXTRACT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rem       <= perm_rank;
          pos       <= '0;
          dig       <= '0;
          res_value <= '0;
          err       <= (perm_rank >= fact(n_eff));
        end
      end
      ST_EXTRACT: begin
        if (ge) begin
          rem <= rem - fval;
          dig <= dig + 4'd1;
        end
      end
      ST_TRAVEL: begin
        if (tok_link[MAX_LEN].valid) begin
          res_value <= tok_link[MAX_LEN].value;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          element_value <= err ? '0 : res_value;
          last_element  <= is_last;
          rank_error    <= err;
          pos           <= pos + 4'd1;
          dig           <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    elem_valid && rank_error |-> last_element && (element_value == '0))
    else $error("error beat must close the answer with value zero");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    elem_valid && !rank_error |-> element_value < n_eff)
    else $error("element value outside permutation length");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid_vec) <= 1)
    else $error("more than one token in the cell chain");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRAVEL) |-> rank_stall && !tok_link[0].valid)
    else $error("chain busy while a new digit or rank enters");

endmodule

FILE: rtl/core/prmu_cell.sv
// One cell of the digit chain: holds an earlier digit and bumps the passing token.
// Depends on prmu_pkg for the token and slot types.
module prmu_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           shift,
  input  prmu_pkg::slot_t slot_i,
  output prmu_pkg::slot_t slot_o,
  input  prmu_pkg::tok_t  tok_i,
  output prmu_pkg::tok_t  tok_o
);
  import prmu_pkg::*;

  logic              bump;
  logic              tok_valid;
  logic [ELEM_W-1:0] tok_value;
  logic              slot_occ;
  logic [ELEM_W-1:0] slot_digit;

  // An earlier digit at or below the running value pushes it up by one.
  assign bump = slot_occ && (slot_digit <= tok_i.value);

  assign tok_o.valid  = tok_valid;
  assign tok_o.value  = tok_value;
  assign slot_o.occ   = slot_occ;
  assign slot_o.digit = slot_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      slot_occ  <= 1'b0;
    end else begin
      tok_valid <= tok_i.valid;
      if (clear) begin
        slot_occ <= 1'b0;
      end else if (shift) begin
        slot_occ <= slot_i.occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_value <= tok_i.value + {{(ELEM_W-1){1'b0}}, bump};
    if (shift) begin
      slot_digit <= slot_i.digit;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for permutation_unrank: directed table, then random ranks
// under several handshake idling phases. Depends on prmu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import prmu_pkg::*;

  localparam int MAX_N = 12;
  localparam int REG_PERM_LENGTH = 0;
  localparam int REG_UNUSED = 1;
  localparam int DRAIN_CYCLES = 200;

  typedef enum {K_PRED, K_IDENT, K_REV, K_ERR} chk_e;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
    logic              err;
  } elem_t;

  typedef struct {
    int                wr_idx;
    logic [31:0]       wr_val;
    logic [RANK_W-1:0] rank;
    chk_e              kind;
  } row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              rank_valid;
  logic              rank_stall;
  logic [RANK_W-1:0] perm_rank;
  logic              elem_valid;
  logic              elem_stall;
  logic [ELEM_W-1:0] element_value;
  logic              last_element;
  logic              rank_error;

  elem_t       expected_elems[$];
  logic [3:0]  cfg_len;
  int          send_pct;
  int          stall_pct;
  int          fail_count;
  int          ranks_sent;
  int          ranks_too_big;
  int          beats_checked;
  logic [15:0] lens_seen;

  permutation_unrank #(.MAX_LEN(MAX_N)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rank_valid(rank_valid), .rank_stall(rank_stall), .perm_rank(perm_rank),
    .elem_valid(elem_valid), .elem_stall(elem_stall),
    .element_value(element_value), .last_element(last_element),
    .rank_error(rank_error)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned fact_of(input int k);
    longint unsigned p;
    int i;
    p = 1;
    for (i = 2; i <= k; i++) p = p * i;
    return p;
  endfunction

  // Lengths 0 and above MAX_N fold back into range.
  function automatic int eff_len();
    int n;
    n = cfg_len;
    if (n == 0) n = 1;
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  function automatic void push_elem(input int value, input bit last, input bit err);
    elem_t e;
    e.value = value[ELEM_W-1:0];
    e.last = last;
    e.err = err;
    expected_elems.push_back(e);
  endfunction

  function automatic void unrank_perm(input logic [RANK_W-1:0] r);
    longint unsigned rem;
    longint unsigned f;
    int unsigned d[MAX_N];
    int n;
    int i;
    int j;
    n = eff_len();
    if (r >= fact_of(n)) begin
      push_elem(0, 1'b1, 1'b1);
      return;
    end
    rem = r;
    for (i = 0; i < n; i++) begin
      f = fact_of(n - 1 - i);
      d[i] = int'(rem / f);
      rem = rem % f;
    end
    // bump each digit once per earlier digit at or below it, nearest first
    for (i = n - 1; i > 0; i--) begin
      for (j = i - 1; j >= 0; j--) begin
        if (d[j] <= d[i]) d[i]++;
      end
    end
    for (i = 0; i < n; i++) push_elem(d[i], i == n - 1, 1'b0);
  endfunction

  function automatic void record_rank(input logic [RANK_W-1:0] r, input chk_e kind);
    int n;
    int i;
    n = eff_len();
    ranks_sent++;
    lens_seen[cfg_len] = 1'b1;
    if (r >= fact_of(n)) ranks_too_big++;
    case (kind)
      K_IDENT: for (i = 0; i < n; i++) push_elem(i, i == n - 1, 1'b0);
      K_REV:   for (i = 0; i < n; i++) push_elem(n - 1 - i, i == n - 1, 1'b0);
      K_ERR:   push_elem(0, 1'b1, 1'b1);
      default: unrank_perm(r);
    endcase
  endfunction

  // Receiver side: random stall, drop to none during reset.
  always @(negedge clk) begin
    if (rst) begin
      elem_stall <= 1'b0;
    end else begin
      elem_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : elem_check
    elem_t got;
    elem_t want;
    if (!rst && elem_valid && !elem_stall) begin
      got.value = element_value;
      got.last = last_element;
      got.err = rank_error;
      beats_checked++;
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected element beat value=%0d last=%0b err=%0b",
                 $time, got.value, got.last, got.err);
        fail_count++;
      end else begin
        want = expected_elems.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: element_value expected %0d actual %0d", $time, want.value, got.value);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_element expected %0b actual %0b", $time, want.last, got.last);
          fail_count++;
        end
        if (got.err !== want.err) begin
          $display("%0t: rank_error expected %0b actual %0b", $time, want.err, got.err);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PERM_LENGTH) cfg_len = val[3:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_length_reg();
    logic [DATA_W-1:0] want;
    want = {{(DATA_W-4){1'b0}}, cfg_len};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'(REG_PERM_LENGTH * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: perm_length readback expected %0d actual %0d", $time, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_rank(input logic [RANK_W-1:0] r, input chk_e kind);
    @(negedge clk);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      rank_valid <= 1'b0;
      @(negedge clk);
    end
    rank_valid <= 1'b1;
    perm_rank <= r;
    do @(posedge clk); while (rank_stall);
    record_rank(r, kind);
  endtask

  // Hold the rank side idle until every expected element has come back.
  task automatic drain();
    @(negedge clk);
    rank_valid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
  endtask

  function automatic logic [RANK_W-1:0] pick_rank();
    longint unsigned f;
    longint unsigned span;
    int pick;
    f = fact_of(eff_len());
    span = (longint'(1) << RANK_W) - f;
    pick = $urandom_range(0, 99);
    if (pick < 3) return RANK_W'(f);
    if (pick < 12) return RANK_W'(f + ({$urandom, $urandom} % span));
    if (pick < 16) return RANK_W'(f - 1);
    if (pick < 18) return '0;
    return RANK_W'({$urandom, $urandom} % f);
  endfunction

  function automatic logic [3:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 4'd1;
      1: return 4'd12;
      2: return ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      default: return 4'($urandom_range(2, 11));
    endcase
  endfunction

  row_t plan [25];

  initial begin : stimulus
    int r;
    int mode;
    int seg;
    int k;
    logic [3:0] len;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rank_valid = 1'b0;
    perm_rank = '0;
    cfg_len = 4'd12;
    send_pct = 0;
    stall_pct = 0;
    fail_count = 0;
    ranks_sent = 0;
    ranks_too_big = 0;
    beats_checked = 0;
    lens_seen = '0;

    plan = '{
      '{-1, 32'd0, 29'd0, K_IDENT},
      '{-1, 32'd0, 29'd479001599, K_REV},
      '{-1, 32'd0, 29'd479001600, K_ERR},
      '{-1, 32'd0, 29'h1FFFFFFF, K_ERR},
      '{-1, 32'd0, 29'h0AAAAAAA, K_PRED},
      '{-1, 32'd0, 29'h15555555, K_PRED},
      '{REG_PERM_LENGTH, 32'd1, 29'd0, K_IDENT},
      '{-1, 32'd0, 29'd1, K_ERR},
      '{REG_PERM_LENGTH, 32'd0, 29'd0, K_IDENT},
      '{-1, 32'd0, 29'd1, K_ERR},
      '{REG_PERM_LENGTH, 32'd15, 29'd479001599, K_REV},
      '{REG_PERM_LENGTH, 32'hFFFF_FFFD, 29'd12345678, K_PRED},
      '{REG_PERM_LENGTH, 32'd14, 29'd479001600, K_ERR},
      '{REG_PERM_LENGTH, 32'd2, 29'd0, K_IDENT},
      '{-1, 32'd0, 29'd1, K_REV},
      '{-1, 32'd0, 29'd2, K_ERR},
      '{REG_PERM_LENGTH, 32'd3, 29'd3, K_PRED},
      '{-1, 32'd0, 29'd5, K_REV},
      '{-1, 32'd0, 29'd6, K_ERR},
      '{REG_PERM_LENGTH, 32'd4, 29'd23, K_REV},
      '{-1, 32'd0, 29'd10, K_PRED},
      '{REG_PERM_LENGTH, 32'd11, 29'd39916799, K_REV},
      '{-1, 32'd0, 29'd39916800, K_ERR},
      '{REG_PERM_LENGTH, 32'd7, 29'd2500, K_PRED},
      // write to an unmapped register must leave the length at 7
      '{REG_UNUSED, 32'd3, 29'd5039, K_REV}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_length_reg();
    for (r = 0; r < 25; r++) begin
      if (plan[r].wr_idx >= 0) begin
        drain();
        write_reg(plan[r].wr_idx, plan[r].wr_val);
        check_length_reg();
      end
      send_rank(plan[r].rank, plan[r].kind);
    end

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 45; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 45; end
        default: begin send_pct = 30; stall_pct = 30; end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        drain();
        len = pick_len();
        write_reg(REG_PERM_LENGTH, 32'({$urandom, 4'h0}) | 32'(len));
        check_length_reg();
        for (k = 0; k < 24; k++) send_rank(pick_rank(), K_PRED);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ranks (%0d out of range), %0d element beats checked",
             ranks_sent, ranks_too_big, beats_checked);
    $display("length register settings seen (bit per value): %b", lens_seen);
    if (fail_count == 0 && expected_elems.size() == 0) begin
      $display("status: pass");
    end else begin
      if (expected_elems.size() != 0)
        $display("%0t: %0d expected element beats never arrived", $time, expected_elems.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("%0t: run timed out", $time);
    $display("status: fail");
    $finish;
  end

endmodule
